// ----- rtl/core/threefish256_reduced_rounds_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the Threefish-256 round pipeline
// Shared concurrent assertion forms, clocked on clock and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef THREEFISH256_REDUCED_ROUNDS_MACROS_SVH
`define THREEFISH256_REDUCED_ROUNDS_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define TF_ASSERT_IMPL(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("tf256 assertion failed");

// Antecedent implies consequent a fixed number of cycles later.
`define TF_ASSERT_DELAY(lbl, ante, dly, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> ##dly (cons)) \
      else $error("tf256 latency assertion failed");

`endif

// ----- rtl/core/tf256_pkg.sv -----
// ----------------------------------------------------------------------------
// tf256_pkg
// Types and constants of the keyless reduced-round Threefish-256 pipeline.
// ----------------------------------------------------------------------------
package tf256_pkg;

   localparam int WordWidth  = 64;
   localparam int RotWidth   = 6;
   localparam int RoundsWidth = 4;
   localparam int TableWidth = 48;
   localparam int CsrIdxWidth = 2;

   // Register indexes of the configuration port.
   localparam logic [CsrIdxWidth-1:0] CSR_NUM_ROUNDS   = 2'd0;
   localparam logic [CsrIdxWidth-1:0] CSR_ROT_TABLE_LO = 2'd1;
   localparam logic [CsrIdxWidth-1:0] CSR_ROT_TABLE_HI = 2'd2;

   localparam logic [RoundsWidth-1:0] ResetNumRounds = 4'd8;
   localparam logic [TableWidth-1:0]  ResetRotLo     = 48'd163114668999694;
   localparam logic [TableWidth-1:0]  ResetRotHi     = 48'd142961110345817;

   typedef struct packed {
      logic [WordWidth-1:0] word0_in;
      logic [WordWidth-1:0] word1_in;
      logic [WordWidth-1:0] word2_in;
      logic [WordWidth-1:0] word3_in;
   } req_type;

   typedef struct packed {
      logic [WordWidth-1:0] word0_out;
      logic [WordWidth-1:0] word1_out;
      logic [WordWidth-1:0] word2_out;
      logic [WordWidth-1:0] word3_out;
   } rsp_type;

   typedef struct packed {
      logic [WordWidth-1:0] w0;
      logic [WordWidth-1:0] w1;
      logic [WordWidth-1:0] w2;
      logic [WordWidth-1:0] w3;
   } state_type;

   // Per-stage control: whether the round runs, whether words 1 and 3 are
   // swapped first, and the two rotation amounts.
   typedef struct packed {
      logic                apply;
      logic                swap;
      logic [RotWidth-1:0] rot_a;
      logic [RotWidth-1:0] rot_b;
   } ctrl_type;

endpackage

// ----- rtl/core/tf256_round.sv -----
// ----------------------------------------------------------------------------
// tf256_round
// One pipeline stage: optional word swap, two MIX operations, stage register.
// ----------------------------------------------------------------------------
module tf256_round (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  tf256_pkg::state_type in_state,
   input  tf256_pkg::ctrl_type  ctrl,
   output logic                 out_valid,
   output tf256_pkg::state_type out_state
);

   logic                 valid_ff;
   tf256_pkg::state_type state_ff;
   tf256_pkg::state_type state_in;
   tf256_pkg::state_type swapped;
   logic [2*tf256_pkg::WordWidth-1:0] rot_a_dbl;
   logic [2*tf256_pkg::WordWidth-1:0] rot_b_dbl;
   logic [tf256_pkg::WordWidth-1:0]   sum_a;
   logic [tf256_pkg::WordWidth-1:0]   sum_b;

   always_comb begin
      swapped = in_state;
      if (ctrl.swap) begin
         swapped.w1 = in_state.w3;
         swapped.w3 = in_state.w1;
      end
      sum_a     = swapped.w0 + swapped.w1;
      sum_b     = swapped.w2 + swapped.w3;
      // Rotate left: the upper half of the doubled word after a left shift.
      rot_a_dbl = {swapped.w1, swapped.w1} << ctrl.rot_a;
      rot_b_dbl = {swapped.w3, swapped.w3} << ctrl.rot_b;
      state_in  = in_state;
      if (ctrl.apply) begin
         state_in.w0 = sum_a;
         state_in.w1 = rot_a_dbl[2*tf256_pkg::WordWidth-1:tf256_pkg::WordWidth] ^ sum_a;
         state_in.w2 = sum_b;
         state_in.w3 = rot_b_dbl[2*tf256_pkg::WordWidth-1:tf256_pkg::WordWidth] ^ sum_b;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      state_ff <= state_in;
   end

   assign out_valid = valid_ff;
   assign out_state = state_ff;

endmodule

// ----- rtl/core/threefish256_reduced_rounds.sv -----
// ----------------------------------------------------------------------------
// threefish256_reduced_rounds
// Keyless reduced-round Threefish-256 mixing pipeline, one block per cycle.
// ----------------------------------------------------------------------------
// A 256-bit block (four 64-bit words) is taken whenever start is high; busy
// is never raised, so a new block may be issued in every cycle. Each block
// passes an input register and then MAX_ROUNDS round stages, one Threefish
// round per stage. The input register loads at the edge that takes the block
// and the round stages then load one after another, so the result word is
// driven onto rsp_data by the last round stage with rsp_valid high and is
// accepted in issue order. The result is shown for a single
// cycle and cannot be held off; the receiver must take it then. Stages beyond
// num_rounds pass their word through unchanged, so the latency does not
// depend on the round count. The round count and rotation tables are read
// directly by every stage; they may only be written while no block is in
// flight. A round count of zero returns the input unchanged, and a count
// above MAX_ROUNDS is treated as MAX_ROUNDS. The configuration port is always
// ready; writes to an index beyond the three registers are dropped.
// ----------------------------------------------------------------------------
module threefish256_reduced_rounds #(
   parameter int MAX_ROUNDS = 8
) (
   input  logic                                    clock,
   input  logic                                    reset,
   // Block input.
   input  logic                                    start,
   output logic                                    busy,
   input  tf256_pkg::req_type                      req_data,
   // Block result.
   output logic                                    rsp_valid,
   output tf256_pkg::rsp_type                      rsp_data,
   // Configuration writes.
   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic [tf256_pkg::CsrIdxWidth-1:0]       csr_index,
   input  logic [tf256_pkg::TableWidth-1:0]        csr_wdata
);

   // Configuration registers.
   logic [tf256_pkg::RoundsWidth-1:0] num_rounds_ff;
   logic [tf256_pkg::TableWidth-1:0]  rot_lo_ff;
   logic [tf256_pkg::TableWidth-1:0]  rot_hi_ff;
   logic [tf256_pkg::RoundsWidth-1:0] rounds_eff;

   // Input capture stage.
   logic                 in_valid_ff;
   tf256_pkg::state_type in_state_ff;

   // Stage outputs; entry 0 is the input register, entry r+1 follows round r.
   logic                 stage_valid [MAX_ROUNDS+1];
   tf256_pkg::state_type stage_state [MAX_ROUNDS+1];

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         num_rounds_ff <= tf256_pkg::ResetNumRounds;
         rot_lo_ff     <= tf256_pkg::ResetRotLo;
         rot_hi_ff     <= tf256_pkg::ResetRotHi;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            tf256_pkg::CSR_NUM_ROUNDS: begin
               num_rounds_ff <= csr_wdata[tf256_pkg::RoundsWidth-1:0];
            end
            tf256_pkg::CSR_ROT_TABLE_LO: begin
               rot_lo_ff <= csr_wdata;
            end
            tf256_pkg::CSR_ROT_TABLE_HI: begin
               rot_hi_ff <= csr_wdata;
            end
            default: begin
            end
         endcase
      end
   end

   // Counts above the pipeline depth saturate at the depth.
   assign rounds_eff = (num_rounds_ff > tf256_pkg::RoundsWidth'(MAX_ROUNDS)) ?
                       tf256_pkg::RoundsWidth'(MAX_ROUNDS) : num_rounds_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= start && !busy;
      end
   end

   always_ff @(posedge clock) begin
      in_state_ff <= '{w0: req_data.word0_in, w1: req_data.word1_in,
                       w2: req_data.word2_in, w3: req_data.word3_in};
   end

   assign stage_valid[0] = in_valid_ff;
   assign stage_state[0] = in_state_ff;

   // One stage per round. Round r takes its rotation pair from the low table
   // for rounds 0 to 3 and from the high table for rounds 4 to 7. The swap of
   // words 1 and 3 that sits between rounds is done at the head of the next
   // round, and only if that round runs, so there is no swap after the last.
   for (genvar r = 0; r < MAX_ROUNDS; r++) begin : g_round
      localparam int PosA = ((r % 4) * 2) * tf256_pkg::RotWidth;
      localparam int PosB = PosA + tf256_pkg::RotWidth;
      localparam bit First = (r == 0);
      localparam bit UseLo = (r < 4);

      tf256_pkg::ctrl_type               ctrl;
      logic [tf256_pkg::TableWidth-1:0] table_sel;

      assign table_sel  = UseLo ? rot_lo_ff : rot_hi_ff;
      assign ctrl.apply = (tf256_pkg::RoundsWidth'(r) < rounds_eff);
      assign ctrl.swap  = ctrl.apply && !First;
      assign ctrl.rot_a = table_sel[PosA +: tf256_pkg::RotWidth];
      assign ctrl.rot_b = table_sel[PosB +: tf256_pkg::RotWidth];

      tf256_round u_round (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (stage_valid[r]),
         .in_state  (stage_state[r]),
         .ctrl      (ctrl),
         .out_valid (stage_valid[r+1]),
         .out_state (stage_state[r+1])
      );
   end

   assign rsp_valid          = stage_valid[MAX_ROUNDS];
   assign rsp_data.word0_out = stage_state[MAX_ROUNDS].w0;
   assign rsp_data.word1_out = stage_state[MAX_ROUNDS].w1;
   assign rsp_data.word2_out = stage_state[MAX_ROUNDS].w2;
   assign rsp_data.word3_out = stage_state[MAX_ROUNDS].w3;

endmodule

// ----- rtl/core/tf256_checker.sv -----
// ----------------------------------------------------------------------------
// tf256_checker
// Port-level checks of the Threefish-256 round pipeline, bound to the top.
// ----------------------------------------------------------------------------
`include "threefish256_reduced_rounds_macros.svh"

module tf256_checker #(
   parameter int MAX_ROUNDS = 8
) (
   input logic                              clock,
   input logic                              reset,
   input logic                              start,
   input logic                              busy,
   input logic                              rsp_valid,
   input logic                              csr_valid,
   input logic                              csr_ready
);

   localparam int Latency = MAX_ROUNDS + 1;

   // Every accepted word comes out after the fixed pipeline latency.
   `TF_ASSERT_DELAY(a_word_returns, start && !busy, Latency, rsp_valid)

   // No result word appears without a word taken the latency earlier.
   `TF_ASSERT_IMPL(a_no_phantom, rsp_valid, $past(start && !busy, Latency))

   // The pipeline never stalls the issuer, and configuration is never held off.
   `TF_ASSERT_IMPL(a_never_busy, start, !busy)
   `TF_ASSERT_IMPL(a_csr_taken, csr_valid, csr_ready)

endmodule

bind threefish256_reduced_rounds tf256_checker #(.MAX_ROUNDS(MAX_ROUNDS)) u_tf256_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .csr_valid (csr_valid),
   .csr_ready (csr_ready)
);
